// File: design/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: result status codes and the
// leading-ones count used to classify lead bytes. No dependencies.
package utf8d_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_BAD_CONT = 2'd3
  } status_t;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Number of leading one bits in a byte, 0 to 8.
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    begin
      casez (b)
        8'b0???????: n = 4'd0;
        8'b10??????: n = 4'd1;
        8'b110?????: n = 4'd2;
        8'b1110????: n = 4'd3;
        8'b11110???: n = 4'd4;
        8'b111110??: n = 4'd5;
        8'b1111110?: n = 4'd6;
        8'b11111110: n = 4'd7;
        default:     n = 4'd8;
      endcase
      return n;
    end
  endfunction

endpackage

// File: design/utf8_stream_decoder.sv
// UTF-8 stream decoder top level, including the legacy 5- and 6-byte forms.
// Depends on utf8d_pkg for status codes and the leading-ones count.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   input   | in        | in_valid, in_ready, in_data_byte, in_stream_end
//   result  | out       | out_valid, out_ready, out_code_point, out_status
//
// One byte request is taken per clock. Each request is decoded in a single
// pass of combinational logic into the sequence state and the result
// register, so a result appears the cycle after the byte that completes it.
// Reset (rst_n low, synchronous) closes any open sequence and empties the
// result register. The input stalls only while a result is held and the
// output side is not taking it; a result taken in the same cycle frees the
// register for the next request.
module utf8_stream_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_stream_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [30:0]              out_code_point,
  output utf8d_pkg::status_t       out_status
);
  import utf8d_pkg::*;

  // Sequence state.
  logic [2:0]  bytes_remaining_r, bytes_remaining_nxt;
  logic [30:0] partial_value_r, partial_value_nxt;
  logic        continuation_bad_r, continuation_bad_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_code_point_r, out_code_point_nxt;
  status_t     out_status_r, out_status_nxt;

  logic        accept;
  logic        emit;
  logic [30:0] emit_cp;
  status_t     emit_st;
  logic [3:0]  n_ones;
  logic        cont_bad_now;
  logic [30:0] shifted;
  logic [2:0]  rem_dec;
  logic [7:0]  lead_mask;

  // The result register may be refilled in the cycle it is emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign n_ones       = lead_ones(in_data_byte);
  assign lead_mask    = 8'hFF >> n_ones;
  assign cont_bad_now = (in_data_byte & CONT_MASK) != CONT_TAG;
  assign shifted      = {partial_value_r[24:0], in_data_byte[5:0]};
  assign rem_dec      = bytes_remaining_r - 3'd1;

  always_comb begin
    bytes_remaining_nxt  = bytes_remaining_r;
    partial_value_nxt    = partial_value_r;
    continuation_bad_nxt = continuation_bad_r;
    emit                 = 1'b0;
    emit_cp              = '0;
    emit_st              = ST_OK;

    if (accept) begin
      if (in_stream_end) begin
        // End of stream in mid-sequence reports truncation; otherwise silent.
        if (bytes_remaining_r != 3'd0) begin
          emit                 = 1'b1;
          emit_st              = ST_TRUNC;
          bytes_remaining_nxt  = 3'd0;
          partial_value_nxt    = '0;
          continuation_bad_nxt = 1'b0;
        end
      end else if (bytes_remaining_r == 3'd0) begin
        // Lead byte: ASCII passes straight through, a stray continuation
        // byte or 0xFE/0xFF is an error, anything else opens a sequence.
        if (n_ones == 4'd0) begin
          emit    = 1'b1;
          emit_cp = {23'd0, in_data_byte};
        end else if (n_ones == 4'd1 || n_ones >= 4'd7) begin
          emit    = 1'b1;
          emit_st = ST_BAD_LEAD;
        end else begin
          partial_value_nxt    = {23'd0, in_data_byte & lead_mask};
          bytes_remaining_nxt  = n_ones[2:0] - 3'd1;
          continuation_bad_nxt = 1'b0;
        end
      end else begin
        // Continuation byte: always consumed, its form checked only at the end.
        if (rem_dec == 3'd0) begin
          emit = 1'b1;
          if (continuation_bad_r || cont_bad_now) begin
            emit_st = ST_BAD_CONT;
          end else begin
            emit_cp = shifted;
          end
          bytes_remaining_nxt  = 3'd0;
          partial_value_nxt    = '0;
          continuation_bad_nxt = 1'b0;
        end else begin
          bytes_remaining_nxt  = rem_dec;
          partial_value_nxt    = shifted;
          continuation_bad_nxt = continuation_bad_r || cont_bad_now;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_code_point_nxt = out_code_point_r;
    out_status_nxt     = out_status_r;
    if (emit) begin
      out_valid_nxt      = 1'b1;
      out_code_point_nxt = emit_cp;
      out_status_nxt     = emit_st;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_remaining_r  <= 3'd0;
      partial_value_r    <= '0;
      continuation_bad_r <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      bytes_remaining_r  <= bytes_remaining_nxt;
      partial_value_r    <= partial_value_nxt;
      continuation_bad_r <= continuation_bad_nxt;
      out_valid_r        <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    out_code_point_r <= out_code_point_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;
  assign out_status     = out_status_r;

`ifndef SYNTH
  // At most five continuation bytes are ever outstanding.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_remaining_r <= 3'd5)
    else $error("bytes_remaining out of range");

  // Error results always carry a zero code point.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_code_point_r == 31'd0)
    else $error("error result with non-zero code point");

  // An end-of-stream request always leaves no sequence open.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_stream_end |=> bytes_remaining_r == 3'd0)
    else $error("sequence still open after end of stream");

  // A truncation result can only follow an end-of-stream request.
  a_trunc_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_status_r == ST_TRUNC |-> $past(in_stream_end))
    else $error("truncation reported without end of stream");
`endif

endmodule
